@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SCMIX_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define SCMIX_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/scmix_pkg.sv @@
// Package for the soft-clip channel mixer: command types, codes and constants.
`default_nettype none

package scmix_pkg;

   // Register indexes of the configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LISTENER_CHANNELS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LISTENER_GAIN     = 1'd1;

   // Channel count code for stereo; every other code means mono
   localparam logic [1:0] CH_STEREO = 2'd2;

   // Unity gain in unsigned Q1.15
   localparam logic [15:0] GAIN_UNITY = 16'h8000;

   // Operation issued to the shared multiplier
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_GAIN,
      MUL_SAMPLE_A,
      MUL_SAMPLE_B,
      MUL_SQUARE,
      MUL_POWER
   } mul_op_type;

   // Which value the soft-clip unit works on and where its result goes
   typedef enum logic [1:0] {
      CLIP_CONTRIB,
      CLIP_FIRST,
      CLIP_SECOND
   } clip_sel_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,
      ST_MUL_A,
      ST_MUL_B,
      ST_CLIP_LOAD,
      ST_PWR_TEST,
      ST_PWR_SQ,
      ST_PWR_MUL,
      ST_CLIP_DONE,
      ST_ACCUM,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic         load_item;
      mul_op_type   mul_op;
      logic         clip_load;
      logic         clip_done;
      clip_sel_type clip_sel;
      logic         accum;
      logic         emit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic listener_stereo;
      logic sound_stereo;
      logic last;
      logic i_zero;
   } dp_status_type;

endpackage

`default_nettype wire

@@ rtl/core/scmix_datapath.sv @@
// Datapath of the mixer: config registers, shared multiplier, soft clip, accumulators.
`default_nettype none

module scmix_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_SOUNDS  = 64
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_write,
   input  wire  [scmix_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire  [15:0]                            csr_wdata,
   input  wire  signed [SAMPLE_BITS-1:0]          req_left_sample,
   input  wire  signed [SAMPLE_BITS-1:0]          req_right_sample,
   input  wire  [1:0]                             req_sound_channels,
   input  wire  [15:0]                            req_sound_gain,
   input  wire                                    req_last_sound,
   output logic signed [SAMPLE_BITS-1:0]          rsp_out_first,
   output logic signed [SAMPLE_BITS-1:0]          rsp_out_second,
   input  scmix_pkg::dp_cmd_type                  cmd,
   output scmix_pkg::dp_status_type               status
);
   import scmix_pkg::*;

   localparam int F   = SAMPLE_BITS - 1;
   localparam int ACC = SAMPLE_BITS + 8;
   localparam int CW  = SAMPLE_BITS + 2;
   localparam int NW  = $clog2(MAX_SOUNDS + 1);
   localparam int AW  = (SAMPLE_BITS + 2 > 17) ? SAMPLE_BITS + 2 : 17;
   localparam int BW  = (SAMPLE_BITS + 1 > 17) ? SAMPLE_BITS + 1 : 17;
   localparam int PW  = AW + BW;
   localparam logic [SAMPLE_BITS-1:0] ONE     = {1'b1, {F{1'b0}}};
   localparam logic [ACC-1:0]         ACC_MAX = {1'b0, {(ACC-1){1'b1}}};
   localparam logic [ACC-1:0]         ACC_MIN = {1'b1, {(ACC-1){1'b0}}};

   // Clamp a Q1.15 gain to unity
   function automatic logic [15:0] gain_sat(input logic [15:0] g);
      return (g > GAIN_UNITY) ? GAIN_UNITY : g;
   endfunction

   // Add a contribution to an accumulator, saturating at its range
   function automatic logic [ACC-1:0] sat_add(input logic [ACC-1:0] s,
                                              input logic [CW-1:0] c);
      logic [ACC:0] total;
      total = {s[ACC-1], s} + {{(ACC+1-CW){c[CW-1]}}, c};
      if (total[ACC] != total[ACC-1]) begin
         return total[ACC] ? ACC_MIN : ACC_MAX;
      end
      return total[ACC-1:0];
   endfunction

   // Configuration registers
   logic [1:0]  cfg_channels_ff;
   logic [15:0] cfg_gain_ff;

   // Latched item
   logic signed [SAMPLE_BITS-1:0] left_ff;
   logic signed [SAMPLE_BITS-1:0] right_ff;
   logic                          snd_stereo_ff;
   logic [15:0]                   sgain_ff;
   logic                          last_ff;

   // Working registers
   logic [15:0]            vol_ff;
   logic [CW-1:0]          c1_ff;
   logic [CW-1:0]          c2_ff;
   logic [SAMPLE_BITS-1:0] x_ff;
   logic [SAMPLE_BITS-1:0] p_ff;
   logic [NW-1:0]          i_ff;
   logic                   neg_ff;
   logic [SAMPLE_BITS-1:0] res_first_ff;
   logic [SAMPLE_BITS-1:0] res_second_ff;
   logic [SAMPLE_BITS-1:0] rsp_first_ff;
   logic [SAMPLE_BITS-1:0] rsp_second_ff;

   // Frame state
   logic [ACC-1:0] sum_first_ff;
   logic [ACC-1:0] sum_first_in;
   logic [ACC-1:0] sum_second_ff;
   logic [ACC-1:0] sum_second_in;
   logic [NW-1:0]  count_ff;
   logic [NW-1:0]  count_in;

   logic                   lst_stereo;
   logic signed [AW-1:0]   mul_a;
   logic signed [BW-1:0]   mul_b;
   logic signed [PW-1:0]   prod;
   logic [ACC-1:0]         src_v;
   logic                   src_neg;
   logic [ACC-1:0]         src_mag;
   logic [SAMPLE_BITS-1:0] clip_a;
   logic [SAMPLE_BITS-1:0] clip_x;
   logic [NW-1:0]          clip_n;
   logic [SAMPLE_BITS-1:0] clip_r;
   logic [SAMPLE_BITS-1:0] clip_res;

   assign lst_stereo = (cfg_channels_ff == CH_STEREO);

   // Select multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         MUL_GAIN: begin
            mul_a = AW'(sgain_ff);
            mul_b = BW'(gain_sat(cfg_gain_ff));
         end
         MUL_SAMPLE_A: begin
            mul_a = (!lst_stereo && snd_stereo_ff) ? AW'(left_ff) + AW'(right_ff)
                                                   : AW'(left_ff);
            mul_b = BW'(vol_ff);
         end
         MUL_SAMPLE_B: begin
            mul_a = snd_stereo_ff ? AW'(right_ff) : AW'(left_ff);
            mul_b = BW'(vol_ff);
         end
         MUL_SQUARE: begin
            mul_a = AW'(x_ff);
            mul_b = BW'(x_ff);
         end
         MUL_POWER: begin
            mul_a = AW'(p_ff);
            mul_b = BW'(x_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = PW'(mul_a) * PW'(mul_b);

   // Pick the value to soft-clip and form 1 - min(|v|, 1)
   always_comb begin
      case (cmd.clip_sel)
         CLIP_CONTRIB: src_v = {{(ACC-CW){c1_ff[CW-1]}}, c1_ff};
         CLIP_FIRST:   src_v = sum_first_ff;
         CLIP_SECOND:  src_v = sum_second_ff;
         default:      src_v = sum_first_ff;
      endcase
      src_neg = src_v[ACC-1];
      src_mag = src_neg ? (~src_v + ACC'(1)) : src_v;
      clip_a  = (src_mag > ACC'(ONE)) ? ONE : src_mag[SAMPLE_BITS-1:0];
      clip_x  = ONE - clip_a;
      clip_n  = (cmd.clip_sel == CLIP_CONTRIB) ? NW'(2) : count_ff;
   end

   // Finish the clip: r = 1 - p, apply the sign, keep positive full scale in range
   always_comb begin
      clip_r = ONE - p_ff;
      if (neg_ff) begin
         clip_res = ~clip_r + SAMPLE_BITS'(1);
      end else if (clip_r >= ONE) begin
         clip_res = ONE - SAMPLE_BITS'(1);
      end else begin
         clip_res = clip_r;
      end
   end

   // Next accumulator and count values
   always_comb begin
      sum_first_in  = sum_first_ff;
      sum_second_in = sum_second_ff;
      count_in      = count_ff;
      if (cmd.accum) begin
         sum_first_in = sat_add(sum_first_ff, c1_ff);
         if (lst_stereo) begin
            sum_second_in = sat_add(sum_second_ff, c2_ff);
         end
         if (count_ff < NW'(MAX_SOUNDS)) begin
            count_in = count_ff + NW'(1);
         end
      end else if (cmd.emit) begin
         sum_first_in  = '0;
         sum_second_in = '0;
         count_in      = '0;
      end
   end

   // Hold configuration and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_channels_ff <= CH_STEREO;
         cfg_gain_ff     <= GAIN_UNITY;
         sum_first_ff    <= '0;
         sum_second_ff   <= '0;
         count_ff        <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LISTENER_CHANNELS: cfg_channels_ff <= csr_wdata[1:0];
               CSR_LISTENER_GAIN:     cfg_gain_ff     <= csr_wdata;
               default:               cfg_gain_ff     <= cfg_gain_ff;
            endcase
         end
         sum_first_ff  <= sum_first_in;
         sum_second_ff <= sum_second_in;
         count_ff      <= count_in;
      end
   end

   // Latch the item and advance the working registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         left_ff       <= req_left_sample;
         right_ff      <= req_right_sample;
         snd_stereo_ff <= (req_sound_channels == CH_STEREO);
         sgain_ff      <= gain_sat(req_sound_gain);
         last_ff       <= req_last_sound;
      end
      case (cmd.mul_op)
         MUL_GAIN:     vol_ff <= prod[15 +: 16];
         MUL_SAMPLE_A: c1_ff  <= prod[15 +: CW];
         MUL_SAMPLE_B: c2_ff  <= prod[15 +: CW];
         MUL_SQUARE:   x_ff   <= prod[F +: SAMPLE_BITS];
         MUL_POWER: begin
            if (i_ff[0]) begin
               p_ff <= prod[F +: SAMPLE_BITS];
            end
            i_ff <= i_ff >> 1;
         end
         default: begin
            vol_ff <= vol_ff;
         end
      endcase
      if (cmd.clip_load) begin
         x_ff   <= clip_x;
         p_ff   <= clip_n[0] ? clip_x : ONE;
         i_ff   <= clip_n >> 1;
         neg_ff <= src_neg;
      end
      if (cmd.clip_done) begin
         case (cmd.clip_sel)
            CLIP_CONTRIB: c1_ff         <= {{(CW-SAMPLE_BITS){clip_res[F]}}, clip_res};
            CLIP_FIRST:   res_first_ff  <= clip_res;
            CLIP_SECOND:  res_second_ff <= clip_res;
            default:      res_first_ff  <= res_first_ff;
         endcase
      end
      if (cmd.emit) begin
         rsp_first_ff  <= res_first_ff;
         rsp_second_ff <= lst_stereo ? res_second_ff : '0;
      end
   end

   assign rsp_out_first  = rsp_first_ff;
   assign rsp_out_second = rsp_second_ff;

   assign status.listener_stereo = lst_stereo;
   assign status.sound_stereo    = snd_stereo_ff;
   assign status.last            = last_ff;
   assign status.i_zero          = (i_ff == '0);

endmodule

`default_nettype wire

@@ rtl/core/scmix_ctrl.sv @@
// Controller of the mixer: sequences each item and the frame-end soft clip.
`default_nettype none

module scmix_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   input  scmix_pkg::dp_status_type  status,
   output scmix_pkg::dp_cmd_type     cmd
);
   import scmix_pkg::*;

   state_type    state_ff;
   state_type    state_in;
   clip_sel_type phase_ff;
   clip_sel_type phase_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_GAIN;
            end
         end
         ST_GAIN:  state_in = ST_MUL_A;
         ST_MUL_A: begin
            if (status.listener_stereo) begin
               state_in = ST_MUL_B;
            end else if (status.sound_stereo) begin
               state_in = ST_CLIP_LOAD;
               phase_in = CLIP_CONTRIB;
            end else begin
               state_in = ST_ACCUM;
            end
         end
         ST_MUL_B:     state_in = ST_ACCUM;
         ST_CLIP_LOAD: state_in = ST_PWR_TEST;
         ST_PWR_TEST:  state_in = status.i_zero ? ST_CLIP_DONE : ST_PWR_SQ;
         ST_PWR_SQ:    state_in = ST_PWR_MUL;
         ST_PWR_MUL:   state_in = ST_PWR_TEST;
         ST_CLIP_DONE: begin
            if (phase_ff == CLIP_CONTRIB) begin
               state_in = ST_ACCUM;
            end else if (phase_ff == CLIP_FIRST && status.listener_stereo) begin
               state_in = ST_CLIP_LOAD;
               phase_in = CLIP_SECOND;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_ACCUM: begin
            if (status.last) begin
               state_in = ST_CLIP_LOAD;
               phase_in = CLIP_FIRST;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd           = '0;
      cmd.mul_op    = MUL_NONE;
      cmd.clip_sel  = phase_ff;
      case (state_ff)
         ST_IDLE:      cmd.load_item = req_valid;
         ST_GAIN:      cmd.mul_op    = MUL_GAIN;
         ST_MUL_A:     cmd.mul_op    = MUL_SAMPLE_A;
         ST_MUL_B:     cmd.mul_op    = MUL_SAMPLE_B;
         ST_CLIP_LOAD: cmd.clip_load = 1'b1;
         ST_PWR_SQ:    cmd.mul_op    = MUL_SQUARE;
         ST_PWR_MUL:   cmd.mul_op    = MUL_POWER;
         ST_CLIP_DONE: cmd.clip_done = 1'b1;
         ST_ACCUM:     cmd.accum     = 1'b1;
         ST_EMIT:      cmd.emit      = slot_free;
         default:      cmd.mul_op    = MUL_NONE;
      endcase
   end

   // Output slot: set on emit, drop once taken
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= CLIP_CONTRIB;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/core/soft_clip_channel_mixer.sv @@
// Top level of the soft-clip channel mixer.
// Each item is one sound's contribution to an audio frame: its sample (mono or stereo)
// is scaled by sound gain times listener gain, mapped to the listener channel count and
// added into saturating accumulators; the item flagged last soft-clips each accumulator
// as sign(v)*(1-(1-|v|)^n) with n the sound count and emits one frame. A single
// multiplier is shared by all steps, so an item runs them in turn: the gain product,
// one sample product (mono listener) or two (stereo listener), for a stereo sound mixed
// down to mono the clip with n = 2, and the accumulate. The last item adds, per output
// channel, the clip and its square-and-multiply power loop, with n up to MAX_SOUNDS,
// then loads the output register once free. The output register lets the next item
// be accepted while a frame waits to be taken.
`default_nettype none
`include "assert_macros.svh"

module soft_clip_channel_mixer #(
   parameter int SAMPLE_BITS = 16,
   parameter int MAX_SOUNDS  = 64
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write,
   input  wire  [scmix_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire  [15:0]                           csr_wdata,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [SAMPLE_BITS-1:0]         req_left_sample,
   input  wire  signed [SAMPLE_BITS-1:0]         req_right_sample,
   input  wire  [1:0]                            req_sound_channels,
   input  wire  [15:0]                           req_sound_gain,
   input  wire                                   req_last_sound,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_first,
   output logic signed [SAMPLE_BITS-1:0]         rsp_out_second
);
   import scmix_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer
   scmix_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and state
   scmix_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SOUNDS  (MAX_SOUNDS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_sound_channels (req_sound_channels),
      .req_sound_gain     (req_sound_gain),
      .req_last_sound     (req_last_sound),
      .rsp_out_first      (rsp_out_first),
      .rsp_out_second     (rsp_out_second),
      .cmd                (cmd),
      .status             (status)
   );

   // An accepted item starts with the gain product
   `SCMIX_ASSERT_NXT(a_accept_starts_gain, clock, reset,
      req_valid && !req_stall, cmd.mul_op == MUL_GAIN,
      "accepted item did not start with the gain step")
   // A frame is loaded only into a free output slot
   `SCMIX_ASSERT_IMP(a_emit_slot_free, clock, reset,
      cmd.emit, !rsp_valid || !rsp_stall,
      "frame loaded over a waiting frame")
   // A loaded frame is offered in the next cycle
   `SCMIX_ASSERT_NXT(a_emit_shows_valid, clock, reset,
      cmd.emit, rsp_valid,
      "loaded frame not offered")
   // The clip finishes only after the power loop has run out
   `SCMIX_ASSERT_IMP(a_clip_done_loop_end, clock, reset,
      cmd.clip_done, status.i_zero,
      "clip finished with power loop still running")

endmodule

`default_nettype wire
